>>> rtl/itrt_pkg.sv
package itrt_pkg;

   // Payload widths of the two channels.
   localparam int CMD_W   = 2;
   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 8;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RADIX_W    = 5;

   // Register indexes, taken from the word address.
   localparam logic REG_RADIX = 1'b0;
   localparam logic REG_UPPER = 1'b1;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_SIGNED32   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNSIGNED32 = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HEX_LOWER  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_HEX_UPPER  = 2'd3;

   // Digit store geometry.
   localparam int DIGIT_DEPTH = 32;
   localparam int DIGIT_W     = 4;
   localparam int IDX_W       = $clog2(DIGIT_DEPTH);
   localparam int NUM_W       = $clog2(DIGIT_DEPTH + 1);

   // Radix handling.
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   // The divider takes one byte of the quotient per cycle.
   localparam int BITS_PER_STEP = 8;
   localparam int NARROW_W      = 32;
   localparam int NARROW_STEPS  = NARROW_W / BITS_PER_STEP;
   localparam int WIDE_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int CNT_W         = $clog2(WIDE_STEPS + 1);

   // Character constants.
   localparam logic [CHAR_W-1:0] MINUS_CHAR  = 8'h2d;
   localparam logic [CHAR_W-1:0] ZERO_CHAR   = 8'h30;
   localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
   localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
   localparam int                FIX_LEN     = 10;
   localparam logic [CHAR_W-1:0] ALL_ONES_TEXT [FIX_LEN] =
      '{8'h34, 8'h32, 8'h39, 8'h34, 8'h39, 8'h36, 8'h37, 8'h32, 8'h39, 8'h35};

   // Microcode.
   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_SIGN,
      ACT_DIV_INIT,
      ACT_DIV_STEP,
      ACT_STORE,
      ACT_READ,
      ACT_EMIT,
      ACT_FIXCHAR
   } act_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_FIXED,
      C_DIV_MORE,
      C_DIGIT_MORE,
      C_EMIT_MORE,
      C_FIX_MORE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      pc_type   target;
   } ctl_word_type;

   // Control handed from the sequencer to the datapath.
   typedef struct packed {
      act_type act;
      logic    fire;
   } seq_ctl_type;

   // Status handed from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic neg;
      logic fixed;
      logic div_more;
      logic digit_more;
      logic emit_more;
      logic fix_more;
   } seq_stat_type;

   // Program store entry points.
   localparam pc_type PC_LOAD  = 4'd0;
   localparam pc_type PC_DIV   = 4'd2;
   localparam pc_type PC_STEP  = 4'd3;
   localparam pc_type PC_READ  = 4'd5;
   localparam pc_type PC_FIXED = 4'd8;

   // The conversion program.
   function automatic ctl_word_type prog_rom(pc_type pc);
      ctl_word_type w;
      unique case (pc)
         4'd0:    w = '{ACT_LOAD,     C_FIXED,      PC_FIXED};
         4'd1:    w = '{ACT_SIGN,     C_NEXT,       PC_LOAD};
         4'd2:    w = '{ACT_DIV_INIT, C_NEXT,       PC_LOAD};
         4'd3:    w = '{ACT_DIV_STEP, C_DIV_MORE,   PC_STEP};
         4'd4:    w = '{ACT_STORE,    C_DIGIT_MORE, PC_DIV};
         4'd5:    w = '{ACT_READ,     C_NEXT,       PC_LOAD};
         4'd6:    w = '{ACT_EMIT,     C_EMIT_MORE,  PC_READ};
         4'd7:    w = '{ACT_NOP,      C_ALWAYS,     PC_LOAD};
         4'd8:    w = '{ACT_FIXCHAR,  C_FIX_MORE,   PC_FIXED};
         default: w = '{ACT_NOP,      C_ALWAYS,     PC_LOAD};
      endcase
      return w;
   endfunction

   // ASCII code of one digit value.
   function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic up);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return ZERO_CHAR + ext;
      end
      return (up ? UPPER_A : LOWER_A) + ext - 8'd10;
   endfunction

endpackage

>>> rtl/itrt_channels.sv
interface itrt_req_if
   import itrt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface itrt_rsp_if
   import itrt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/integer_to_radix_text.sv
// Channel  Direction  Beat contents
// req_if   in         cmd (2 b), value (64 b): one number to convert
// rsp_if   out        char_code (8 b), last (1 b): one character of the text
// csr_*    in/out     APB registers: radix at 0x0, upper_letters at 0x4
//
// One number at a time. A microcoded sequencer divides the quotient by the
// radix one byte per cycle, storing one digit per division; then each
// character is read back from the digit store and sent. A minus sign goes
// out in the sign step, which every number but the unsigned all-ones word
// passes through. The unsigned all-ones word goes out as a fixed text.
// Reset is synchronous; the digit store is not cleared. A stalled rsp_if
// holds the sequencer at its next sign, emit or fixed-text step; a new
// number is taken while the final character still waits in the output
// register.
module integer_to_radix_text
   import itrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   itrt_req_if.sink              req_if,
   itrt_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   seq_ctl_type  ctl;
   seq_stat_type stat;

   // Configuration registers.
   logic [RADIX_W-1:0] radix_ff;
   logic               upper_ff;

   // Datapath registers.
   logic [VALUE_W-1:0] q_ff, q_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   n_ff, n_in;
   logic               neg_ff, neg_in;
   logic               wide_ff, wide_in;
   logic               upitem_ff, upitem_in;
   logic [DIGIT_W-1:0] rd_ff;

   // Output register.
   logic              ovalid_ff, ovalid_in;
   logic [CHAR_W-1:0] ochar_ff, ochar_in;
   logic              olast_ff, olast_in;
   logic              out_load;

   // Digit store.
   logic [DIGIT_W-1:0] store [DIGIT_DEPTH];
   logic [NUM_W-1:0]   n_m1;

   // Input decode.
   logic                wr_en;
   logic [NARROW_W-1:0] low_word;
   logic                in_neg;
   logic                in_fixed;
   logic [RADIX_W-1:0]  clamp_radix;

   // Divider step.
   logic [BITS_PER_STEP-1:0] div_byte;
   logic [BITS_PER_STEP-1:0] div_qb;
   logic [DIGIT_W-1:0]       div_r;
   logic [DIGIT_W:0]         div_t;

   itrt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // APB register port.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         upper_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            REG_RADIX: radix_ff <= csr_pwdata[RADIX_W-1:0];
            REG_UPPER: upper_ff <= csr_pwdata[0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RADIX: csr_prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff};
         REG_UPPER: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, upper_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // Decode of the incoming number.
   always_comb begin
      low_word = req_if.value[NARROW_W-1:0];
      in_neg   = (req_if.cmd == CMD_SIGNED32) && low_word[NARROW_W-1];
      in_fixed = (req_if.cmd == CMD_UNSIGNED32) && (&low_word);
      if (radix_ff < RADIX_MIN) begin
         clamp_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         clamp_radix = RADIX_MAX;
      end else begin
         clamp_radix = radix_ff;
      end
   end

   // One byte of long division: eight restoring steps on a narrow remainder.
   always_comb begin
      div_byte = wide_ff ? q_ff[VALUE_W-1 -: BITS_PER_STEP]
                         : q_ff[NARROW_W-1 -: BITS_PER_STEP];
      div_r    = rem_ff;
      div_qb   = '0;
      div_t    = '0;
      for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
         div_t = {div_r, div_byte[i]};
         if (div_t >= base_ff) begin
            div_qb[i] = 1'b1;
            div_t     = div_t - base_ff;
         end
         div_r = div_t[DIGIT_W-1:0];
      end
   end

   // Status for the sequencer.
   always_comb begin
      stat.req_valid  = req_if.valid;
      stat.out_free   = !ovalid_ff || rsp_if.ready;
      stat.neg        = neg_ff;
      stat.fixed      = in_fixed;
      stat.div_more   = (cnt_ff != CNT_W'(1));
      stat.digit_more = (q_ff != '0) && (n_ff != NUM_W'(DIGIT_DEPTH - 1));
      stat.emit_more  = (n_ff != '0);
      stat.fix_more   = (n_ff != NUM_W'(FIX_LEN - 1));
   end

   assign req_if.ready = (ctl.act == ACT_LOAD);
   assign n_m1         = n_ff - 1'b1;

   // Datapath actions driven by the control word.
   always_comb begin
      q_in      = q_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      neg_in    = neg_ff;
      wide_in   = wide_ff;
      upitem_in = upitem_ff;
      out_load  = 1'b0;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;

      if (ctl.fire) begin
         unique case (ctl.act)
            ACT_LOAD: begin
               n_in    = '0;
               rem_in  = '0;
               neg_in  = in_neg;
               wide_in = req_if.cmd[1];
               if (req_if.cmd[1]) begin
                  q_in      = req_if.value;
                  base_in   = RADIX_MAX;
                  upitem_in = (req_if.cmd == CMD_HEX_UPPER);
               end else begin
                  q_in      = {{(VALUE_W-NARROW_W){1'b0}},
                               (in_neg ? (~low_word + 1'b1) : low_word)};
                  base_in   = clamp_radix;
                  upitem_in = upper_ff;
               end
            end
            ACT_SIGN: begin
               if (neg_ff) begin
                  out_load = 1'b1;
                  ochar_in = MINUS_CHAR;
                  olast_in = 1'b0;
               end
            end
            ACT_DIV_INIT: begin
               rem_in = '0;
               cnt_in = wide_ff ? CNT_W'(WIDE_STEPS) : CNT_W'(NARROW_STEPS);
            end
            ACT_DIV_STEP: begin
               rem_in = div_r;
               cnt_in = cnt_ff - 1'b1;
               if (wide_ff) begin
                  q_in = {q_ff[VALUE_W-BITS_PER_STEP-1:0], div_qb};
               end else begin
                  q_in = {{(VALUE_W-NARROW_W){1'b0}},
                          q_ff[NARROW_W-BITS_PER_STEP-1:0], div_qb};
               end
            end
            ACT_STORE: begin
               n_in = n_ff + 1'b1;
            end
            ACT_READ: begin
               n_in = n_m1;
            end
            ACT_EMIT: begin
               out_load = 1'b1;
               ochar_in = digit_char(rd_ff, upitem_ff);
               olast_in = (n_ff == '0);
            end
            ACT_FIXCHAR: begin
               out_load = 1'b1;
               ochar_in = ALL_ONES_TEXT[n_ff[$clog2(FIX_LEN)-1:0]];
               olast_in = (n_ff == NUM_W'(FIX_LEN - 1));
               n_in     = n_ff + 1'b1;
            end
            default: ;
         endcase
      end

      if (out_load) begin
         ovalid_in = 1'b1;
      end else if (rsp_if.ready) begin
         ovalid_in = 1'b0;
      end else begin
         ovalid_in = ovalid_ff;
      end
   end

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= '0;
         cnt_ff    <= '0;
         rem_ff    <= '0;
         base_ff   <= RADIX_MAX;
         neg_ff    <= 1'b0;
         wide_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         n_ff      <= n_in;
         cnt_ff    <= cnt_in;
         rem_ff    <= rem_in;
         base_ff   <= base_in;
         neg_ff    <= neg_in;
         wide_ff   <= wide_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      upitem_ff <= upitem_in;
      ochar_ff  <= ochar_in;
      olast_ff  <= olast_in;
   end

   // Digit store: written on each new digit, read back most significant first.
   always_ff @(posedge clock) begin
      if (ctl.fire && ctl.act == ACT_STORE) begin
         store[n_ff[IDX_W-1:0]] <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire && ctl.act == ACT_READ) begin
         rd_ff <= store[n_m1[IDX_W-1:0]];
      end
   end

   assign rsp_if.valid     = ovalid_ff;
   assign rsp_if.char_code = ochar_ff;
   assign rsp_if.last      = olast_ff;

   // A new number always starts with an empty digit count.
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (n_ff == '0))
      else $error("digit count not cleared on a new number");

   // The digit count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NUM_W'(DIGIT_DEPTH))
      else $error("digit count beyond store depth");

   // The remainder stays a valid digit of the current base.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff < base_ff)
      else $error("remainder not below the radix");

   // The divider never runs with an exhausted byte count.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.act == ACT_DIV_STEP) |-> (cnt_ff != '0))
      else $error("divide step with zero byte count");

endmodule

>>> rtl/itrt_seq.sv
module itrt_seq
   import itrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output seq_ctl_type  ctl
);

   pc_type       pc_ff;
   pc_type       pc_in;
   ctl_word_type word;
   logic         stall;
   logic         take;

   // Decode the current control word, work out stalls and the jump.
   always_comb begin
      word = prog_rom(pc_ff);

      unique case (word.act)
         ACT_LOAD:    stall = !stat.req_valid;
         ACT_SIGN:    stall = stat.neg && !stat.out_free;
         ACT_EMIT:    stall = !stat.out_free;
         ACT_FIXCHAR: stall = !stat.out_free;
         default:     stall = 1'b0;
      endcase

      unique case (word.cond)
         C_NEXT:       take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_FIXED:      take = stat.fixed;
         C_DIV_MORE:   take = stat.div_more;
         C_DIGIT_MORE: take = stat.digit_more;
         C_EMIT_MORE:  take = stat.emit_more;
         C_FIX_MORE:   take = stat.fix_more;
         default:      take = 1'b0;
      endcase

      if (stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end

      ctl.act  = word.act;
      ctl.fire = !stall;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> verif/integer_to_radix_text_checker.sv
module integer_to_radix_text_checker
   import itrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   itrt_req_if                   req_mon,
   itrt_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    chars_due
);

   // Decimal text of the unsigned all-ones word, first character in the top byte.
   localparam logic [79:0] ALL_ONES_DEC = "4294967295";

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              fin;
   } text_char_type;

   logic [RADIX_W-1:0] cfg_radix;
   logic               cfg_upper;
   text_char_type      text_due[$];

   // Works out the characters of one number and queues them in output order.
   function automatic void predict_text(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] num);
      logic [DIGIT_W-1:0] digs[DIGIT_DEPTH];
      logic [CHAR_W-1:0]  chars[$];
      logic [VALUE_W-1:0] quot;
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] rem;
      logic [31:0]        mag;
      logic [DIGIT_W-1:0] d;
      logic               up;
      logic               fixed_text;
      int                 n;

      fixed_text = 1'b0;
      if (op == CMD_SIGNED32 || op == CMD_UNSIGNED32) begin
         // Out-of-range radix settings are pulled back into two through sixteen.
         if (cfg_radix < RADIX_MIN) begin
            base = VALUE_W'(RADIX_MIN);
         end else if (cfg_radix > RADIX_MAX) begin
            base = VALUE_W'(RADIX_MAX);
         end else begin
            base = VALUE_W'(cfg_radix);
         end
         up   = cfg_upper;
         quot = {32'b0, num[31:0]};
         if (op == CMD_UNSIGNED32 && num[31:0] == 32'hFFFF_FFFF) begin
            // The unsigned all-ones word always prints in decimal.
            fixed_text = 1'b1;
            for (int i = 0; i < 10; i++) begin
               chars.push_back(ALL_ONES_DEC[8*(9-i) +: 8]);
            end
         end else if (op == CMD_SIGNED32 && num[31]) begin
            chars.push_back(MINUS_CHAR);
            mag  = ~num[31:0] + 32'd1;
            quot = {32'b0, mag};
         end
      end else begin
         base = 64'd16;
         up   = (op == CMD_HEX_UPPER);
         quot = num;
      end

      if (!fixed_text) begin
         // Digits come out least significant first; zero still gives one digit.
         n = 0;
         do begin
            rem     = quot % base;
            digs[n] = rem[DIGIT_W-1:0];
            quot    = quot / base;
            n++;
         end while (quot != 0 && n < DIGIT_DEPTH);
         for (int i = n - 1; i >= 0; i--) begin
            d = digs[i];
            if (d < 4'd10) begin
               chars.push_back(ZERO_CHAR + CHAR_W'(d));
            end else begin
               chars.push_back((up ? UPPER_A : LOWER_A) + CHAR_W'(d) - 8'd10);
            end
         end
      end

      for (int i = 0; i < chars.size(); i++) begin
         text_due.push_back('{chars[i], i == chars.size() - 1});
      end
   endfunction

   // Follow the register writes, check every result beat and predict every input beat.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         cfg_radix  = RADIX_RESET;
         cfg_upper  = 1'b0;
         mismatches = 0;
         text_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_RADIX) begin
               cfg_radix = csr_pwdata[RADIX_W-1:0];
            end else begin
               cfg_upper = csr_pwdata[0];
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (text_due.size() == 0) begin
               $display("%0t: unexpected character %h last %b, nothing expected", $time,
                        rsp_mon.char_code, rsp_mon.last);
               mismatches++;
            end else begin
               want = text_due.pop_front();
               if (want.code !== rsp_mon.char_code || want.fin !== rsp_mon.last) begin
                  $display("%0t: character mismatch: expected %h last %b, got %h last %b",
                           $time, want.code, want.fin, rsp_mon.char_code, rsp_mon.last);
                  mismatches++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            predict_text(req_mon.cmd, req_mon.value);
         end
      end
      chars_due = text_due.size();
   end

endmodule

>>> verif/integer_to_radix_text_test.sv
module integer_to_radix_text_test
   import itrt_pkg::*;
();

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 500;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 36;
   localparam logic [CSR_ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UPPER_ADDR = {REG_UPPER, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    chars_due;
   logic                  no_idle;
   logic                  hold_request;

   itrt_req_if req_if ();
   itrt_rsp_if rsp_if ();

   integer_to_radix_text dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   integer_to_radix_text_checker text_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .chars_due   (chars_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   // Offers one number and returns once the beat is taken, after an optional pause.
   task automatic send_number(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] num);
      int gap;
      req_if.valid <= 1'b1;
      req_if.cmd   <= op;
      req_if.value <= num;
      do @(posedge clock); while (!req_if.ready);
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every expected character has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (chars_due != 0);
      @(posedge clock);
   endtask

   // One APB write; the bus is left selected so writes can follow back to back.
   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_format(logic [RADIX_W-1:0] radix, logic upper);
      wait_drained();
      write_reg(RADIX_ADDR, CSR_DATA_W'(radix));
      write_reg(UPPER_ADDR, CSR_DATA_W'(upper));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Result side: random stalls, one long hold-off on request, none in quiet phases.
   initial begin
      int stall_left;
      logic hold_taken;
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      hold_taken   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (no_idle || $urandom_range(0, 99) >= 30) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left = idle_length() - 1;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus: directed numbers first, then random phases over several formats.
   initial begin
      logic [CMD_W-1:0]   op;
      logic [VALUE_W-1:0] num;
      logic [RADIX_W-1:0] radix_set;
      int                 phase_radix[PHASES];

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd   = '0;
      req_if.value = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      phase_radix  = '{10, 2, 16, 0, 1, 17, 31, 7, 3, 12};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset format: decimal, lower-case letters.
      send_number(CMD_SIGNED32, 64'h0);
      send_number(CMD_SIGNED32, 64'hFFFF_FFFF_7FFF_FFFF);
      send_number(CMD_SIGNED32, 64'h0000_0000_8000_0000);
      send_number(CMD_SIGNED32, 64'h0000_0000_FFFF_FFFF);
      send_number(CMD_SIGNED32, 64'hA5A5_A5A5_0000_002A);
      send_number(CMD_UNSIGNED32, 64'h0);
      send_number(CMD_UNSIGNED32, 64'h0000_0000_FFFF_FFFF);
      send_number(CMD_UNSIGNED32, 64'h1234_5678_FFFF_FFFE);
      send_number(CMD_UNSIGNED32, 64'hFFFF_FFFF_0000_0009);
      send_number(CMD_HEX_LOWER, 64'h0);
      send_number(CMD_HEX_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(CMD_HEX_LOWER, 64'h0123_4567_89AB_CDEF);
      send_number(CMD_HEX_UPPER, 64'hFEDC_BA98_7654_3210);
      send_number(CMD_HEX_UPPER, 64'h8000_0000_0000_0000);

      // Binary gives the longest texts; all ones still prints in decimal.
      set_format(5'd2, 1'b1);
      send_number(CMD_SIGNED32, 64'h0000_0000_8000_0000);
      send_number(CMD_UNSIGNED32, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(CMD_UNSIGNED32, 64'h0000_0000_FFFF_FFFE);
      send_number(CMD_SIGNED32, 64'h0000_0000_0000_0001);

      set_format(5'd16, 1'b1);
      send_number(CMD_SIGNED32, 64'h0000_0000_FFFF_FFFF);
      send_number(CMD_UNSIGNED32, 64'h0000_0000_DEAD_BEEF);

      // Radix settings outside two through sixteen.
      set_format(5'd0, 1'b0);
      send_number(CMD_UNSIGNED32, 64'h0000_0000_0000_0005);
      set_format(5'd31, 1'b0);
      send_number(CMD_UNSIGNED32, 64'h0000_0000_0000_CAFE);

      for (int phase = 0; phase < PHASES; phase++) begin
         radix_set = (phase == PHASES - 1) ? RADIX_W'($urandom_range(0, 31))
                                           : RADIX_W'(phase_radix[phase]);
         set_format(radix_set, phase[0]);
         no_idle <= (phase == 4 || phase == 7);
         if (phase == 2) begin
            hold_request <= 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            op  = CMD_W'($urandom_range(0, 3));
            num = {$urandom(), $urandom()};
            case ($urandom_range(0, 7))
               0, 1: num = num >> $urandom_range(1, 63);
               2: num[31:0] = $urandom_range(0, 20);
               3: begin
                  case ($urandom_range(0, 3))
                     0: num[31:0] = 32'h0000_0000;
                     1: num[31:0] = 32'hFFFF_FFFF;
                     2: num[31:0] = 32'h8000_0000;
                     default: num[31:0] = 32'h7FFF_FFFF;
                  endcase
               end
               4: num = ($urandom_range(0, 1) == 0) ? '0 : '1;
               default: ;
            endcase
            send_number(op, num);
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
